// ----- rtl/tlbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared widths, sizes and controller/datapath interface types for the
// TLB and FIFO paging block.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int OFFSET_BITS     = 12;
  localparam int PAGE_BITS       = 10;
  localparam int FRAME_BITS      = 8;
  localparam int PAGE_TOTAL      = 1 << PAGE_BITS;
  localparam int FRAME_TOTAL     = 1 << FRAME_BITS;
  localparam int ALLOC_BITS      = FRAME_BITS + 1;
  localparam int STAMP_BITS      = 32;
  localparam int ADDR_BITS       = 32;
  localparam int PHYS_BITS       = FRAME_BITS + OFFSET_BITS;
  localparam int VCOUNT_BITS     = 6;
  localparam int POP_BITS        = 9;
  localparam int TLB_ENTRIES_DEF = 32;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic hit_update;
    logic take_frame;
    logic alloc_new;
    logic fault_full;
    logic evict_start;
    logic evict_flush;
    logic map_page;
    logic slot_pick;
    logic scan_step;
    logic insert;
    logic out_load;
    logic clear_step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic pt_valid;
    logic alloc_full;
    logic any_free;
    logic scan_last;
    logic out_free;
    logic clear_last;
  } sts_t;

endpackage

// ----- rtl/tlbf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_ctrl
// Sequencer: table clear after reset, then lookup, page table walk, FIFO
// replacement, LRU slot choice, TLB insert and result hand-off.
// ----------------------------------------------------------------------------
module tlbf_ctrl
  import tlbf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_PTCHK, S_FIFO, S_EVPT, S_MAP,
    S_SLOT, S_SCAN, S_INS, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.hit) begin
          cmd.hit_update = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_PTCHK;
        end
      end
      S_PTCHK: begin
        if (sts.pt_valid) begin
          cmd.take_frame = 1'b1;
          state_next = S_SLOT;
        end else if (!sts.alloc_full) begin
          cmd.alloc_new = 1'b1;
          state_next = S_SLOT;
        end else begin
          cmd.fault_full = 1'b1;
          state_next = S_FIFO;
        end
      end
      S_FIFO: begin
        cmd.evict_start = 1'b1;
        state_next = S_EVPT;
      end
      S_EVPT: begin
        cmd.evict_flush = 1'b1;
        state_next = S_MAP;
      end
      S_MAP: begin
        cmd.map_page = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot_pick = 1'b1;
        state_next = sts.any_free ? S_INS : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_INS;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/tlbf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbf_dp
// Datapath: TLB entry registers with CAM match, page table and FIFO
// memories, LRU stamp scan and the output register.
// ----------------------------------------------------------------------------
module tlbf_dp
  import tlbf_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [ADDR_BITS-1:0]   vaddr,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [PAGE_BITS-1:0]   page_index,
  output logic [OFFSET_BITS-1:0] page_offset,
  output logic                   tlb_hit,
  output logic                   pg_fault,
  output logic [FRAME_BITS-1:0]  frame,
  output logic [PHYS_BITS-1:0]   paddr,
  output logic                   evicted_valid,
  output logic [PAGE_BITS-1:0]   victim_page,
  output logic                   tlb_flushed,
  output logic [VCOUNT_BITS-1:0] tlb_valid_count,
  output logic                   tlb_removed_valid,
  output logic [PAGE_BITS-1:0]   tlb_removed_page
);

  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  // TLB entries
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [PAGE_BITS-1:0]   tlb_pages  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  tlb_frames [TLB_ENTRIES];
  logic [STAMP_BITS-1:0]  tlb_stamps [TLB_ENTRIES];
  logic [STAMP_BITS-1:0]  use_counter;

  // page table {valid, frame} and FIFO of resident pages
  logic [FRAME_BITS:0]    pt_mem   [PAGE_TOTAL];
  logic [PAGE_BITS-1:0]   fifo_mem [FRAME_TOTAL];
  logic [FRAME_BITS:0]    pt_rdata;
  logic [PAGE_BITS-1:0]   fifo_rdata;
  logic [PAGE_BITS-1:0]   pt_raddr, pt_waddr, clear_idx;
  logic [FRAME_BITS:0]    pt_wdata;
  logic                   pt_we;
  logic [FRAME_BITS-1:0]  fifo_rd_ptr;
  logic [ALLOC_BITS-1:0]  frames_allocated;

  // current request and its result
  logic [PAGE_BITS-1:0]   page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic                   hit_q, fault_q, ev_valid_q, flushed_q, rm_valid_q;
  logic [FRAME_BITS-1:0]  frame_q;
  logic [PAGE_BITS-1:0]   ev_page_q, rm_page_q;
  logic [VCOUNT_BITS-1:0] vcount_q;

  // LRU scan
  logic [TW-1:0]          slot, scan_idx;
  logic [STAMP_BITS-1:0]  least;

  // CAM and priority logic
  logic                   hit_any, free_any;
  logic [TW-1:0]          hit_idx, free_idx;
  logic [TLB_ENTRIES-1:0] ev_match;
  logic [POP_BITS-1:0]    pop;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    pop      = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_pages[i] == page_q) begin
        hit_any = 1'b1;
        hit_idx = TW'(i);
      end
      if (!tlb_valid[i]) begin
        free_any = 1'b1;
        free_idx = TW'(i);
      end
      ev_match[i] = tlb_valid[i] && (tlb_pages[i] == ev_page_q);
      pop = pop + POP_BITS'(tlb_valid[i]);
    end
  end

  always_comb begin
    sts.hit        = hit_any;
    sts.pt_valid   = pt_rdata[FRAME_BITS];
    sts.alloc_full = (frames_allocated == ALLOC_BITS'(FRAME_TOTAL));
    sts.any_free   = free_any;
    sts.scan_last  = (scan_idx == TW'(TLB_ENTRIES - 1));
    sts.out_free   = !out_valid || out_ready;
    sts.clear_last = (clear_idx == PAGE_BITS'(PAGE_TOTAL - 1));
  end

  // page table port control
  always_comb begin
    pt_raddr = cmd.evict_start ? fifo_rdata : page_q;
    pt_we    = 1'b0;
    pt_waddr = page_q;
    pt_wdata = '0;
    if (cmd.clear_step) begin
      pt_we    = 1'b1;
      pt_waddr = clear_idx;
    end else if (cmd.alloc_new) begin
      pt_we    = 1'b1;
      pt_wdata = {1'b1, frames_allocated[FRAME_BITS-1:0]};
    end else if (cmd.evict_flush) begin
      pt_we    = 1'b1;
      pt_waddr = ev_page_q;
    end else if (cmd.map_page) begin
      pt_we    = 1'b1;
      pt_wdata = {1'b1, frame_q};
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rdata <= pt_mem[pt_raddr];
  end

  // FIFO memory, always reading at the head
  always_ff @(posedge clk) begin
    if (cmd.alloc_new) fifo_mem[frames_allocated[FRAME_BITS-1:0]] <= page_q;
    else if (cmd.evict_start) fifo_mem[fifo_rd_ptr] <= page_q;
    fifo_rdata <= fifo_mem[fifo_rd_ptr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid        <= '0;
      use_counter      <= '0;
      fifo_rd_ptr      <= '0;
      frames_allocated <= '0;
      clear_idx        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.clear_step) clear_idx <= clear_idx + 1'b1;
      if (cmd.hit_update || cmd.insert) use_counter <= use_counter + 1'b1;
      if (cmd.alloc_new) frames_allocated <= frames_allocated + 1'b1;
      if (cmd.evict_start) fifo_rd_ptr <= fifo_rd_ptr + 1'b1;
      if (cmd.evict_flush) tlb_valid <= tlb_valid & ~ev_match;
      if (cmd.insert) tlb_valid[slot] <= 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // TLB entry payload
  always_ff @(posedge clk) begin
    if (cmd.hit_update) tlb_stamps[hit_idx] <= use_counter + 1'b1;
    if (cmd.insert) begin
      tlb_pages[slot]  <= page_q;
      tlb_frames[slot] <= frame_q;
      tlb_stamps[slot] <= use_counter + 1'b1;
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      page_q     <= vaddr[OFFSET_BITS +: PAGE_BITS];
      offset_q   <= vaddr[OFFSET_BITS-1:0];
      hit_q      <= 1'b0;
      fault_q    <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
      flushed_q  <= 1'b0;
      vcount_q   <= '0;
      rm_valid_q <= 1'b0;
      rm_page_q  <= '0;
    end
    if (cmd.hit_update) begin
      hit_q   <= 1'b1;
      frame_q <= tlb_frames[hit_idx];
    end
    if (cmd.take_frame) frame_q <= pt_rdata[FRAME_BITS-1:0];
    if (cmd.alloc_new) begin
      fault_q <= 1'b1;
      frame_q <= frames_allocated[FRAME_BITS-1:0];
    end
    if (cmd.fault_full) fault_q <= 1'b1;
    if (cmd.evict_start) begin
      ev_valid_q <= 1'b1;
      ev_page_q  <= fifo_rdata;
    end
    if (cmd.evict_flush) begin
      frame_q   <= pt_rdata[FRAME_BITS-1:0];
      flushed_q <= |ev_match;
    end
    if (cmd.map_page) vcount_q <= flushed_q ? pop[VCOUNT_BITS-1:0] : '0;
    // lowest free slot, or start the stamp scan
    if (cmd.slot_pick) begin
      slot     <= free_any ? free_idx : '0;
      least    <= '1;
      scan_idx <= '0;
    end
    if (cmd.scan_step) begin
      if (tlb_stamps[scan_idx] < least) begin
        least <= tlb_stamps[scan_idx];
        slot  <= scan_idx;
      end
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.insert) begin
      rm_valid_q <= tlb_valid[slot];
      rm_page_q  <= tlb_valid[slot] ? tlb_pages[slot] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      page_index        <= page_q;
      page_offset       <= offset_q;
      tlb_hit           <= hit_q;
      pg_fault          <= fault_q;
      frame             <= frame_q;
      paddr             <= {frame_q, offset_q};
      evicted_valid     <= ev_valid_q;
      victim_page       <= ev_page_q;
      tlb_flushed       <= flushed_q;
      tlb_valid_count   <= vcount_q;
      tlb_removed_valid <= rm_valid_q;
      tlb_removed_page  <= rm_page_q;
    end
  end

endmodule

// ----- rtl/tlb_lru_with_fifo_paging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lru_with_fifo_paging
// From accept to registered result: a TLB hit needs only the lookup; a miss
// adds the page table check, a full frame pool adds FIFO eviction, and an
// LRU stamp scan runs before the insert when the TLB has no free slot.
// One request at a time; the next is taken the cycle after the result is
// registered.
// Reset: synchronous; afterwards a clear of all PAGE_TOTAL (1024) page table
// entries runs before the first request is accepted.
// ----------------------------------------------------------------------------
module tlb_lru_with_fifo_paging
  import tlbf_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ADDR_BITS-1:0]   vaddr,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PAGE_BITS-1:0]   page_index,
  output logic [OFFSET_BITS-1:0] page_offset,
  output logic                   tlb_hit,
  output logic                   pg_fault,
  output logic [FRAME_BITS-1:0]  frame,
  output logic [PHYS_BITS-1:0]   paddr,
  output logic                   evicted_valid,
  output logic [PAGE_BITS-1:0]   victim_page,
  output logic                   tlb_flushed,
  output logic [VCOUNT_BITS-1:0] tlb_valid_count,
  output logic                   tlb_removed_valid,
  output logic [PAGE_BITS-1:0]   tlb_removed_page
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tlbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tlbf_dp #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .vaddr             (vaddr),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .page_index        (page_index),
    .page_offset       (page_offset),
    .tlb_hit           (tlb_hit),
    .pg_fault          (pg_fault),
    .frame             (frame),
    .paddr             (paddr),
    .evicted_valid     (evicted_valid),
    .victim_page       (victim_page),
    .tlb_flushed       (tlb_flushed),
    .tlb_valid_count   (tlb_valid_count),
    .tlb_removed_valid (tlb_removed_valid),
    .tlb_removed_page  (tlb_removed_page)
  );

endmodule

// ----- tb/tlb_lru_with_fifo_paging_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lru_with_fifo_paging_checker
// Watches the request and result channels of the TLB/FIFO paging block,
// keeps its own copy of TLB, page table and FIFO state, predicts each
// translation and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module tlb_lru_with_fifo_paging_checker
  import tlbf_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [ADDR_BITS-1:0]   vaddr,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [PAGE_BITS-1:0]   page_index,
  input  logic [OFFSET_BITS-1:0] page_offset,
  input  logic                   tlb_hit,
  input  logic                   pg_fault,
  input  logic [FRAME_BITS-1:0]  frame,
  input  logic [PHYS_BITS-1:0]   paddr,
  input  logic                   evicted_valid,
  input  logic [PAGE_BITS-1:0]   victim_page,
  input  logic                   tlb_flushed,
  input  logic [VCOUNT_BITS-1:0] tlb_valid_count,
  input  logic                   tlb_removed_valid,
  input  logic [PAGE_BITS-1:0]   tlb_removed_page,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offset;
    logic                   hit;
    logic                   fault;
    logic [FRAME_BITS-1:0]  frm;
    logic [PHYS_BITS-1:0]   phys;
    logic                   ev_valid;
    logic [PAGE_BITS-1:0]   ev_page;
    logic                   flushed;
    logic [VCOUNT_BITS-1:0] vcount;
    logic                   rm_valid;
    logic [PAGE_BITS-1:0]   rm_page;
  } xlate_t;

  // shadow state
  logic                  tlb_v   [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]  tlb_pg  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] tlb_fr  [TLB_ENTRIES];
  logic [STAMP_BITS-1:0] tlb_st  [TLB_ENTRIES];
  logic [STAMP_BITS-1:0] use_cnt;
  logic                  pt_v    [PAGE_TOTAL];
  logic [FRAME_BITS-1:0] pt_fr   [PAGE_TOTAL];
  logic [PAGE_BITS-1:0]  fifo_pg [FRAME_TOTAL];
  logic [FRAME_BITS-1:0] fifo_rd_ptr;
  logic [ALLOC_BITS-1:0] alloc_cnt;

  xlate_t expected_xlates[$];

  function automatic xlate_t translate(logic [ADDR_BITS-1:0] addr);
    xlate_t r;
    int slot;
    logic [STAMP_BITS-1:0] least;
    logic [PAGE_BITS-1:0] victim;
    r = '0;
    r.offset = addr[OFFSET_BITS-1:0];
    r.page   = addr[OFFSET_BITS +: PAGE_BITS];
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_v[i] && tlb_pg[i] == r.page) begin
        r.frm = tlb_fr[i];
        use_cnt = use_cnt + 1;
        tlb_st[i] = use_cnt;
        r.hit = 1'b1;
        break;
      end
    end
    if (!r.hit) begin
      if (pt_v[r.page]) begin
        r.frm = pt_fr[r.page];
      end else begin
        r.fault = 1'b1;
        if (alloc_cnt < FRAME_TOTAL) begin
          r.frm = alloc_cnt[FRAME_BITS-1:0];
          fifo_pg[alloc_cnt[FRAME_BITS-1:0]] = r.page;
          alloc_cnt++;
        end else begin
          // FIFO replacement: drop oldest page and its TLB entry
          victim = fifo_pg[fifo_rd_ptr];
          r.ev_valid = 1'b1;
          r.ev_page = victim;
          r.frm = pt_fr[victim];
          pt_v[victim] = 1'b0;
          for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_v[i] && tlb_pg[i] == victim) begin
              tlb_v[i] = 1'b0;
              r.flushed = 1'b1;
              for (int j = 0; j < TLB_ENTRIES; j++) r.vcount += tlb_v[j];
              break;
            end
          end
          fifo_pg[fifo_rd_ptr] = r.page;
          fifo_rd_ptr++;
        end
        pt_v[r.page] = 1'b1;
        pt_fr[r.page] = r.frm;
      end
      // LRU slot: lowest free, else lowest smallest stamp (slot 0 default)
      slot = 0;
      least = '1;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (!tlb_v[i]) begin
          slot = i;
          break;
        end
        if (tlb_st[i] < least) begin
          least = tlb_st[i];
          slot = i;
        end
      end
      if (tlb_v[slot]) begin
        r.rm_valid = 1'b1;
        r.rm_page = tlb_pg[slot];
      end
      tlb_v[slot] = 1'b1;
      tlb_pg[slot] = r.page;
      tlb_fr[slot] = r.frm;
      use_cnt = use_cnt + 1;
      tlb_st[slot] = use_cnt;
    end
    r.phys = {r.frm, r.offset};
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    xlate_t e;
    if (rst) begin
      foreach (tlb_v[i]) begin
        tlb_v[i] = 1'b0;
        tlb_st[i] = '0;
      end
      foreach (pt_v[i]) pt_v[i] = 1'b0;
      use_cnt = '0;
      fifo_rd_ptr = '0;
      alloc_cnt = '0;
      expected_xlates.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (in_valid && in_ready) expected_xlates.push_back(translate(vaddr));
      if (out_valid && out_ready) begin
        if (expected_xlates.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_xlates.pop_front();
          check_field("page_index", e.page, page_index);
          check_field("page_offset", e.offset, page_offset);
          check_field("tlb_hit", e.hit, tlb_hit);
          check_field("pg_fault", e.fault, pg_fault);
          check_field("frame", e.frm, frame);
          check_field("paddr", e.phys, paddr);
          check_field("evicted_valid", e.ev_valid, evicted_valid);
          check_field("victim_page", e.ev_page, victim_page);
          check_field("tlb_flushed", e.flushed, tlb_flushed);
          check_field("tlb_valid_count", e.vcount, tlb_valid_count);
          check_field("tlb_removed_valid", e.rm_valid, tlb_removed_valid);
          check_field("tlb_removed_page", e.rm_page, tlb_removed_page);
        end
      end
      pending = expected_xlates.size();
    end
  end

endmodule

// ----- tb/tb_tlb_lru_with_fifo_paging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_lru_with_fifo_paging
// Drives address requests into the paging block with random idling on both
// channels: directed corner addresses first, then random working sets that
// exercise TLB hits, LRU eviction and FIFO frame replacement.
// ----------------------------------------------------------------------------
module tb_tlb_lru_with_fifo_paging;
  import tlbf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ADDR_BITS-1:0]   vaddr = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PAGE_BITS-1:0]   page_index;
  logic [OFFSET_BITS-1:0] page_offset;
  logic                   tlb_hit;
  logic                   pg_fault;
  logic [FRAME_BITS-1:0]  frame;
  logic [PHYS_BITS-1:0]   paddr;
  logic                   evicted_valid;
  logic [PAGE_BITS-1:0]   victim_page;
  logic                   tlb_flushed;
  logic [VCOUNT_BITS-1:0] tlb_valid_count;
  logic                   tlb_removed_valid;
  logic [PAGE_BITS-1:0]   tlb_removed_page;
  int                     fail_count;
  int                     pending;
  int                     send_idle_pct = 12;
  int                     recv_idle_pct = 88;
  int                     hold_off = 0;
  int                     cycles = 0;

  always #5 clk = ~clk;

  tlb_lru_with_fifo_paging u_top (.*);

  tlb_lru_with_fifo_paging_checker u_chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays up after acceptance until the next idle cycle or request
  task automatic send_addr(logic [ADDR_BITS-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    vaddr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ADDR_BITS-1:0] make_addr(int pg);
    logic [ADDR_BITS-1:0] a;
    a = $urandom;
    a[OFFSET_BITS +: PAGE_BITS] = pg[PAGE_BITS-1:0];
    return a;
  endfunction

  // random phase: working set sized to hit, thrash the TLB, or thrash frames
  task automatic random_phase(int n);
    int base;
    int span;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        base = $urandom_range(PAGE_TOTAL - 1);
        case ($urandom_range(2))
          0: span = $urandom_range(8, 30);
          1: span = $urandom_range(33, 60);
          default: span = $urandom_range(200, 400);
        endcase
      end
      if ($urandom_range(9) == 0) send_addr($urandom);
      else send_addr(make_addr((base + $urandom_range(span - 1)) % PAGE_TOTAL));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corner addresses, repeat hits, upper bits ignored
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0000_0FFF);
    send_addr(32'hFFC0_0000);
    send_addr(32'h003F_F000);
    send_addr(32'h0000_1000);
    send_addr(32'h0040_0123);
    send_addr(32'hAAAA_AAAA);
    send_addr(32'h5555_5555);
    send_addr(32'h0000_0ABC);
    // distinct pages to fill more TLB entries, still fewer than the TLB size
    for (int p = 2; p < 42; p += 3) send_addr(make_addr(p));

    // sender pauses until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    random_phase(300);

    // long receiver hold-off while requests keep coming
    hold_off = 300;
    for (int i = 0; i < 10; i++) send_addr(make_addr($urandom_range(PAGE_TOTAL - 1)));

    send_idle_pct = 88;
    recv_idle_pct = 12;
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(310);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- tlb_lru_with_fifo_paging.f -----
rtl/tlbf_pkg.sv
rtl/tlbf_ctrl.sv
rtl/tlbf_dp.sv
rtl/tlb_lru_with_fifo_paging.sv
tb/tlb_lru_with_fifo_paging_checker.sv
tb/tb_tlb_lru_with_fifo_paging.sv
